>>> hdl/spirm_pkg.sv
// shared types and constants for the spi register access master
package spirm_pkg;

    localparam logic [7:0]  CMD_WRITE      = 8'h04;
    localparam logic [7:0]  CMD_READ       = 8'h05;
    localparam logic [4:0]  FRAME_BITS     = 5'd24;
    localparam logic [4:0]  READ_SENT_BITS = 5'd16;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } t_opcode;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_LEAD  = 6'b000010,
        PH_SETUP = 6'b000100,
        PH_LOW   = 6'b001000,
        PH_GAP   = 6'b010000,
        PH_TAIL  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       cs_n;
        logic       sck;
        logic       mosi;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
    } t_result;

endpackage

>>> hdl/spirm_seq.sv
// frame sequencer: advances the spi frame by one tick per accepted transaction
module spirm_seq
    import spirm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [15:0] i_half_period,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_miso_bit,
    output t_result     o_result
);

    t_phase      r_phase,     n_phase;
    logic [4:0]  r_bit_index, n_bit_index;
    logic [23:0] r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift,  n_in_shift;
    logic [15:0] r_wait,      n_wait;
    logic        r_is_read,   n_is_read;
    logic        r_cs_n,      n_cs_n;
    logic        r_sck,       n_sck;
    logic        r_mosi,      n_mosi;
    logic [7:0]  r_read_hold, n_read_hold;

    logic        done;
    logic        present;
    logic        start_read;
    logic [15:0] reload;

    assign reload = (i_half_period == 16'd0) ? 16'd0 : i_half_period - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_wait      = r_wait;
        n_is_read   = r_is_read;
        n_cs_n      = r_cs_n;
        n_sck       = r_sck;
        n_mosi      = r_mosi;
        n_read_hold = r_read_hold;
        done        = 1'b0;
        present     = 1'b0;
        start_read  = (i_opcode == OP_READ);

        if (r_phase != PH_IDLE && r_wait != 16'd0) begin
            n_wait = r_wait - 16'd1;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_opcode == OP_WRITE || i_opcode == OP_READ) begin
                        n_is_read   = start_read;
                        n_out_shift = {start_read ? CMD_READ : CMD_WRITE, i_reg_address,
                                       start_read ? 8'd0 : i_write_data};
                        n_bit_index = 5'd0;
                        n_cs_n      = 1'b0;
                        n_phase     = PH_LEAD;
                        n_wait      = reload;
                    end
                end
                PH_LEAD, PH_GAP: begin
                    present = 1'b1;
                end
                PH_SETUP: begin
                    n_sck   = 1'b0;
                    n_phase = PH_LOW;
                    n_wait  = reload;
                end
                PH_LOW: begin
                    n_sck       = 1'b1;
                    n_bit_index = r_bit_index + 5'd1;
                    if (n_bit_index >= FRAME_BITS) begin
                        n_phase = PH_TAIL;
                        n_wait  = reload;
                    end else if (r_is_read && n_bit_index == READ_SENT_BITS) begin
                        n_phase = PH_GAP;
                        n_wait  = reload;
                    end else begin
                        present = 1'b1;
                    end
                end
                PH_TAIL: begin
                    n_cs_n = 1'b1;
                    if (r_is_read) begin
                        n_read_hold = r_in_shift;
                    end
                    n_phase = PH_IDLE;
                    n_wait  = 16'd0;
                    done    = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_wait  = 16'd0;
                end
            endcase
        end

        if (present) begin
            if (r_is_read && n_bit_index >= READ_SENT_BITS) begin
                n_in_shift = {r_in_shift[6:0], i_miso_bit};
            end else begin
                n_mosi      = r_out_shift[23];
                n_out_shift = {r_out_shift[22:0], 1'b0};
            end
            n_phase = PH_SETUP;
            n_wait  = reload;
        end
    end

    assign o_result.cs_n      = n_cs_n;
    assign o_result.sck       = n_sck;
    assign o_result.mosi      = n_mosi;
    assign o_result.busy      = (n_phase != PH_IDLE);
    assign o_result.done      = done;
    assign o_result.read_data = n_read_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= 5'd0;
            r_out_shift <= 24'd0;
            r_in_shift  <= 8'd0;
            r_wait      <= 16'd0;
            r_is_read   <= 1'b0;
            r_cs_n      <= 1'b1;
            r_sck       <= 1'b1;
            r_mosi      <= 1'b0;
            r_read_hold <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_wait      <= n_wait;
            r_is_read   <= n_is_read;
            r_cs_n      <= n_cs_n;
            r_sck       <= n_sck;
            r_mosi      <= n_mosi;
            r_read_hold <= n_read_hold;
        end
    end

    // chip select is low exactly while a frame is open
    a_cs_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cs_n == (r_phase == PH_IDLE))
        else $error("chip select out of step with frame phase");

    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == 16'd0))
        else $error("wait count left running in idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= FRAME_BITS)
        else $error("bit index beyond frame length");

    // clock only goes low between setup and its rising edge
    a_sck_low_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sck |-> (r_phase == PH_LOW))
        else $error("serial clock low outside low phase");

endmodule

>>> hdl/spi_register_access_master.sv
// top level of the spi register access master
//
// Every input transaction is one tick of time: opcode 0 just ticks, opcode 1
// starts a register write, opcode 2 a register read; starts are ignored while
// an access runs. Each accepted transaction yields exactly one output
// transaction with the pin levels after that tick (cs_n, sck, mosi), the busy
// flag, a one-tick done pulse and the byte of the last completed read.
// The result is registered and sits in the output register in the cycle
// after the input is accepted. Throughput, unless the receiver stalls, is one
// transaction per cycle; sequencer state and output register update at once.
// When the receiver stalls, the output register holds its result and the
// input stall is raised only while that register is full and stalled.
// The half-period register is written through the config channel, which is
// always ready; a new value applies from the next delay unit.
// Synchronous reset puts the frame in idle with chip select and clock high,
// data low, read byte zero, half period one, and the output register empty.
module spi_register_access_master
    import spirm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_miso_bit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_cs_n,
    output logic        o_sck,
    output logic        o_mosi,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_half_period
);

    logic [15:0] r_half_period;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic        step;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign step        = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_period <= i_cfg_half_period;
        end
    end

    spirm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_half_period (r_half_period),
        .i_opcode      (i_opcode),
        .i_reg_address (i_reg_address),
        .i_write_data  (i_write_data),
        .i_miso_bit    (i_miso_bit),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cs_n      = r_result.cs_n;
    assign o_sck       = r_result.sck;
    assign o_mosi      = r_result.mosi;
    assign o_busy_res  = r_result.busy;
    assign o_done_res  = r_result.done;
    assign o_read_data = r_result.read_data;

    // done closes the frame, so it never comes with busy or chip select low
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.done) |-> (!r_result.busy && r_result.cs_n))
        else $error("done reported while frame still open");

    a_busy_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.busy == !r_result.cs_n))
        else $error("busy flag disagrees with chip select");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

endmodule
